// ===== design/assert_macros.svh =====
// Assertion macros shared by the colour key span finder RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition in one cycle requires another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition in one cycle requires another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ckspan_pkg.sv =====
// Package for the colour key span and neighbour finder.
// Holds the result event type, event kinds and register indexes; depends on nothing.
`default_nettype none

package ckspan_pkg;

   // Width of a colour and of the fixed result fields.
   localparam int COLOR_W = 24;
   localparam int POS_W   = 12;
   localparam int END_W   = 13;
   localparam int SIZE_W  = 13;

   // Result kinds.
   typedef enum logic {
      EV_SPAN     = 1'b0,
      EV_NEIGHBOR = 1'b1
   } ev_kind_type;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_KEY_COLOR    = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   // One result event as held in the result queue.
   typedef struct packed {
      ev_kind_type          kind;
      logic                 last;
      logic [POS_W-1:0]     span_row;
      logic [POS_W-1:0]     span_start;
      logic [END_W-1:0]     span_end;
      logic [COLOR_W-1:0]   neighbor_color;
   } event_type;

endpackage

`default_nettype wire

// ===== design/ckspan_evq.sv =====
// Result event queue: takes up to three events per cycle and releases one per cycle
// while out_ready is high. Depends on ckspan_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ckspan_evq import ckspan_pkg::*; #(
   parameter int QDEPTH = 8   // power of two, at least 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_en,
   input  wire logic [2:0]           push_valid,
   input  wire event_type [2:0]      push_ent,
   output logic                      room,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output event_type                 out_ent
);

   localparam int AW = $clog2(QDEPTH);
   localparam int CW = AW + 1;

   event_type         q_mem [QDEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     idx1, idx2;
   logic [1:0]        push_num;
   logic              pop;

   // Room for a full group of three events.
   assign room      = (cnt_ff <= CW'(QDEPTH - 3));
   assign out_valid = (cnt_ff != '0);
   assign out_ent   = q_mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Valid events are packed one after another from the write pointer.
   always_comb begin
      push_num  = push_en ? 2'(push_valid[0]) + 2'(push_valid[1]) + 2'(push_valid[2]) : 2'd0;
      idx1      = wr_ptr_ff + AW'(push_valid[0]);
      idx2      = idx1 + AW'(push_valid[1]);
      wr_ptr_in = wr_ptr_ff + AW'(push_num);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      cnt_in    = cnt_ff + CW'(push_num) - CW'(pop);
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_en && push_valid[0]) q_mem[wr_ptr_ff] <= push_ent[0];
      if (push_en && push_valid[1]) q_mem[idx1]      <= push_ent[1];
      if (push_en && push_valid[2]) q_mem[idx2]      <= push_ent[2];
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CW'(QDEPTH), "result queue overfilled")
   `ASSERT_SAME(a_push_room, push_en && (push_valid != 3'b000), room, "push without room")
   `ASSERT_NEXT(a_pop_only, pop && !push_en, cnt_ff == $past(cnt_ff) - CW'(1), "bad pop count")

endmodule

`default_nettype wire

// ===== design/color_key_span_and_neighbor_finder_top.sv =====
// Colour key span and neighbour finder, top level with registers and line store.
// Depends on ckspan_pkg, ckspan_evq and assert_macros.svh.
//
//   Channel | Ports   | Direction | Carries
//   --------+---------+-----------+-------------------------------------------
//   request | req_*   | in        | one pixel colour per request
//   result  | rsp_*   | out       | span or neighbour events, tlast ends a pixel
//   config  | csr_*   | in/out    | key colour, image width, image height
//
// One pixel is taken every cycle unless the second stage stalls; its events are held in the
// second stage register and then written to the queue, from whose head they leave in order.
// The line store is read and written at the same column in the accept cycle, old data first.
// Events leave one per cycle while rsp_tready is high, through an eight-entry queue;
// requests stall while the second stage is full and fewer than three queue entries are free.
// Reset is synchronous and clears counters, run state and queue, not the line store.
`default_nettype none
`include "assert_macros.svh"

module color_key_span_and_neighbor_finder_top import ckspan_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // [23:0] pixel_color
   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // [11:0] span_row, [23:12] span_start,
                                          // [36:24] span_end, [60:37] neighbor_color, rest 0
   output logic              rsp_tuser,   // [0] event_kind
   output logic              rsp_tlast,   // last_of_item
   // Configuration port.
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
   localparam int YW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

   // Configuration registers.
   logic [COLOR_W-1:0] key_ff;
   logic [SIZE_W-1:0]  width_ff;
   logic [SIZE_W-1:0]  height_ff;
   logic               csr_wr;

   // Raster and run state.
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic               run_open_ff, run_open_in;
   logic [CW-1:0]      run_start_ff, run_start_in;
   logic [COLOR_W-1:0] prev_ff;

   // Line store holding the row above.
   logic [COLOR_W-1:0] line_mem [MAX_WIDTH];
   logic [COLOR_W-1:0] above_ff;

   // Second stage registers.
   logic               b_valid_ff, b_valid_in;
   logic [COLOR_W-1:0] b_pix_ff;
   logic [COLOR_W-1:0] b_prev_ff;
   logic               b_left_chk_ff;
   logic               b_above_chk_ff;
   logic               b_span_v_ff;
   logic [POS_W-1:0]   b_row_ff;
   logic [POS_W-1:0]   b_start_ff;
   logic [END_W-1:0]   b_end_ff;

   logic               accept;
   logic [COLOR_W-1:0] pix;
   logic [XW-1:0]      w_ext, width_eff;
   logic [YW-1:0]      h_ext, height_eff;
   logic               row_end;
   logic               row_wrap;
   logic               is_key;
   logic               span_v;
   logic [CW-1:0]      span_start;
   logic [END_W-1:0]   span_end;

   logic               room;
   logic               b_adv;
   logic               b_is_key, left_key, above_key;
   logic               l_v, a_v;
   logic [2:0]         ev_valid;
   event_type [2:0]    ev_ent;
   event_type          head;

   assign pix        = req_tdata[COLOR_W-1:0];
   assign accept     = req_tvalid && req_tready;
   assign b_adv      = b_valid_ff && room;
   assign req_tready = !b_valid_ff || room;

   // Register port: writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         width_ff  <= SIZE_W'(4096);
         height_ff <= SIZE_W'(4096);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_KEY_COLOR:    key_ff    <= csr_pwdata[COLOR_W-1:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_KEY_COLOR:    csr_prdata = 32'(key_ff);
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Effective image size: zero acts as one, large values clip to the maximum.
   always_comb begin
      w_ext = XW'(width_ff);
      h_ext = YW'(height_ff);
      if (w_ext == '0)                 width_eff = XW'(1);
      else if (w_ext > XW'(MAX_WIDTH)) width_eff = XW'(MAX_WIDTH);
      else                             width_eff = w_ext;
      if (h_ext == '0)                  height_eff = YW'(1);
      else if (h_ext > YW'(MAX_HEIGHT)) height_eff = YW'(MAX_HEIGHT);
      else                              height_eff = h_ext;
   end

   // Run tracking and raster position for the accepted pixel.
   always_comb begin
      is_key       = (pix == key_ff);
      row_end      = (XW'(col_ff) + XW'(1) >= width_eff);
      row_wrap     = (YW'(row_ff) + YW'(1) >= height_eff);
      span_v       = 1'b0;
      span_start   = run_start_ff;
      span_end     = END_W'(col_ff);
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      if (is_key) begin
         if (!run_open_ff) begin
            span_start   = col_ff;
            run_start_in = col_ff;
         end
         run_open_in = 1'b1;
         if (row_end) begin
            span_v      = 1'b1;
            span_end    = END_W'({1'b0, col_ff} + (CW + 1)'(1));
            run_open_in = 1'b0;
         end
      end else if (run_open_ff) begin
         span_v      = 1'b1;
         run_open_in = 1'b0;
      end
      if (row_end) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         prev_ff      <= '0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         prev_ff      <= pix;
      end
   end

   // Line store: the old entry is read before the new pixel replaces it.
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff         <= line_mem[col_ff];
         line_mem[col_ff] <= pix;
      end
   end

   // Second stage: holds the pixel until the queue has taken its events.
   always_comb begin
      if (accept)     b_valid_in = 1'b1;
      else if (b_adv) b_valid_in = 1'b0;
      else            b_valid_in = b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= b_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff       <= pix;
         b_prev_ff      <= prev_ff;
         b_left_chk_ff  <= (col_ff != '0);
         b_above_chk_ff <= (row_ff != '0);
         b_span_v_ff    <= span_v;
         b_row_ff       <= POS_W'(row_ff);
         b_start_ff     <= POS_W'(span_start);
         b_end_ff       <= span_end;
      end
   end

   // Event assembly: left neighbour, above neighbour, then span.
   always_comb begin
      b_is_key  = (b_pix_ff == key_ff);
      left_key  = (b_prev_ff == key_ff);
      above_key = (above_ff == key_ff);
      l_v       = b_left_chk_ff && (b_is_key != left_key);
      a_v       = b_above_chk_ff && (b_is_key != above_key);
      ev_valid  = {b_span_v_ff, a_v, l_v};

      ev_ent[0].kind           = EV_NEIGHBOR;
      ev_ent[0].last           = l_v && !a_v && !b_span_v_ff;
      ev_ent[0].span_row       = '0;
      ev_ent[0].span_start     = '0;
      ev_ent[0].span_end       = '0;
      ev_ent[0].neighbor_color = b_is_key ? b_prev_ff : b_pix_ff;

      ev_ent[1].kind           = EV_NEIGHBOR;
      ev_ent[1].last           = a_v && !b_span_v_ff;
      ev_ent[1].span_row       = '0;
      ev_ent[1].span_start     = '0;
      ev_ent[1].span_end       = '0;
      ev_ent[1].neighbor_color = b_is_key ? above_ff : b_pix_ff;

      ev_ent[2].kind           = EV_SPAN;
      ev_ent[2].last           = 1'b1;
      ev_ent[2].span_row       = b_row_ff;
      ev_ent[2].span_start     = b_start_ff;
      ev_ent[2].span_end       = b_end_ff;
      ev_ent[2].neighbor_color = '0;
   end

   ckspan_evq #(
      .QDEPTH (8)
   ) u_evq (
      .clock      (clock),
      .reset      (reset),
      .push_en    (b_adv),
      .push_valid (ev_valid),
      .push_ent   (ev_ent),
      .room       (room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_ent    (head)
   );

   // Result packing.
   assign rsp_tdata = {3'b000, head.neighbor_color, head.span_end,
                       head.span_start, head.span_row};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   `ASSERT_ALWAYS(a_col_bound, XW'(col_ff) < XW'(MAX_WIDTH), "column beyond line store")
   `ASSERT_NEXT(a_row_end_close, accept && row_end, !run_open_ff && (col_ff == '0), "run open at row start")
   `ASSERT_NEXT(a_stage_hold, b_valid_ff && !room, b_valid_ff && $stable(b_pix_ff), "stalled stage lost")

endmodule

`default_nettype wire

// ===== test/color_key_span_and_neighbor_finder_top_tb.sv =====
// Self-checking testbench for the colour key span and neighbour finder top level.
// Depends on ckspan_pkg and color_key_span_and_neighbor_finder_top; reads no files.
// Events of each pixel request are predicted in the bench and compared field by field in order.
`timescale 1ns / 100ps

module color_key_span_and_neighbor_finder_top_tb;
   import ckspan_pkg::*;

   // One expected event, at the widths of the result channel.
   typedef struct packed {
      ev_kind_type  kind;
      logic         last;
      logic [11:0]  row;
      logic [11:0]  first_col;
      logic [12:0]  end_col;
      logic [23:0]  color;
   } finder_event_type;

   // A directed step is either a pixel request or a register write.
   typedef enum logic {
      STEP_PIXEL = 1'b0,
      STEP_WRITE = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type op;
      logic [1:0]    reg_index;
      logic [23:0]   value;
      logic          typed;      // expectation given here rather than predicted
      logic          typed_one;  // one event expected, otherwise none
      ev_kind_type   exp_kind;
      logic [11:0]   exp_row;
      logic [11:0]   exp_first;
      logic [12:0]   exp_end;
      logic [23:0]   exp_color;
   } step_row_type;

   // Directed walk from reset: key 0, width 4096, height 4096.
   localparam step_row_type DIRECTED_STEPS [24] = '{
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'hFFFFFF, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h123456, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b1, 1'b1, EV_NEIGHBOR, 12'd0, 12'd0, 13'd0,
        24'h123456},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  24'd3,      1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b1, 1'b1, EV_SPAN,     12'd0, 12'd4, 13'd6, 24'h0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 24'd2,      1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'hABCDEF, 1'b1, 1'b1, EV_NEIGHBOR, 12'd0, 12'd0, 13'd0,
        24'hABCDEF},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'hFFFFFF, 1'b1, 1'b1, EV_NEIGHBOR, 12'd0, 12'd0, 13'd0,
        24'hFFFFFF},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_KEY_COLOR,    24'hFFFFFF, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'hFFFFFF, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_KEY_COLOR,    24'h123456, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h123456, 1'b1, 1'b1, EV_NEIGHBOR, 12'd0, 12'd0, 13'd0,
        24'hFFFFFF},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000001, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  24'd0,      1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h123456, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h000000, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 24'd1,      1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h123456, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  24'h001FFF, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 24'h001FFF, 1'b0, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0},
      '{STEP_PIXEL, REG_KEY_COLOR,    24'h123456, 1'b1, 1'b0, EV_SPAN,     12'd0, 12'd0, 13'd0, 24'h0}
   };

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;    // [23:0] pixel_color
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;    // [11:0] span_row, [23:12] span_start, [36:24] span_end,
                               // [60:37] neighbor_color, rest 0
   logic         rsp_tuser;    // [0] event_kind
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Register copies and the scan state of the finder.
   logic [23:0]  key_reg;
   logic [12:0]  width_reg;
   logic [12:0]  height_reg;
   int           col_pos;
   int           row_pos;
   logic         run_open;
   int           run_first;
   logic [23:0]  prev_pixel;
   logic [23:0]  line_mem [0:4095];
   int           line_filled;  // line store entries written since reset, from column 0 up

   // Events of the pixel being predicted, and those still awaited from the block.
   finder_event_type pixel_events [3];
   int               pixel_event_count;
   finder_event_type awaited_events [$];

   int send_idle_pct;
   int recv_idle_pct;
   int result_hold_cycles;
   int mismatch_count;
   int pixels_sent;
   int events_checked;
   logic [23:0] other_a;
   logic [23:0] other_b;

   color_key_span_and_neighbor_finder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
   endtask

   // Zero acts as one, anything above 4096 acts as 4096.
   function automatic int size_in_use(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > 13'd4096) return 4096;
      return int'(v);
   endfunction

   function automatic void add_neighbor(input logic [23:0] color);
      finder_event_type ev;
      ev = '0;
      ev.kind = EV_NEIGHBOR;
      ev.color = color;
      pixel_events[pixel_event_count] = ev;
      pixel_event_count++;
   endfunction

   function automatic void add_span(input int first_col, input int end_col);
      finder_event_type ev;
      ev = '0;
      ev.kind = EV_SPAN;
      ev.row = row_pos[11:0];
      ev.first_col = first_col[11:0];
      ev.end_col = end_col[12:0];
      pixel_events[pixel_event_count] = ev;
      pixel_event_count++;
   endfunction

   // Works out the events of one pixel in order: left pair, above pair, then span.
   function automatic void predict_pixel_events(input logic [23:0] pix);
      int   w;
      int   h;
      logic is_key;
      logic side_key;
      logic row_end;
      logic [23:0] above;
      w = size_in_use(width_reg);
      h = size_in_use(height_reg);
      is_key = (pix == key_reg);
      row_end = (col_pos + 1 >= w);
      pixel_event_count = 0;
      if (col_pos != 0) begin
         side_key = (prev_pixel == key_reg);
         if (is_key && !side_key) add_neighbor(prev_pixel);
         else if (!is_key && side_key) add_neighbor(pix);
      end
      if (row_pos != 0) begin
         above = line_mem[col_pos];
         side_key = (above == key_reg);
         if (is_key && !side_key) add_neighbor(above);
         else if (!is_key && side_key) add_neighbor(pix);
      end
      if (is_key) begin
         if (!run_open) begin
            run_open = 1'b1;
            run_first = col_pos;
         end
         if (row_end) add_span(run_first, col_pos + 1);
      end else if (run_open) begin
         add_span(run_first, col_pos);
         run_open = 1'b0;
      end
      line_mem[col_pos] = pix;
      if (col_pos >= line_filled) line_filled = col_pos + 1;
      prev_pixel = pix;
      if (row_end) begin
         col_pos = 0;
         run_open = 1'b0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      if (pixel_event_count > 0) pixel_events[pixel_event_count - 1].last = 1'b1;
   endfunction

   // Offers one pixel request, with random gaps before it, and returns at its acceptance.
   task automatic send_pixel(input logic [23:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic feed_pixel(input logic [23:0] pix);
      int k;
      send_pixel(pix);
      predict_pixel_events(pix);
      for (k = 0; k < pixel_event_count; k++) awaited_events.push_back(pixel_events[k]);
   endtask

   // Stops requests and waits until every awaited event has come and the pipeline is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes one register over the APB port, then reads it back.
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want;
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_KEY_COLOR: begin
            key_reg = value[23:0];
            want = {8'd0, key_reg};
         end
         REG_IMAGE_WIDTH: begin
            width_reg = value[12:0];
            want = {19'd0, width_reg};
         end
         default: begin
            height_reg = value[12:0];
            want = {19'd0, height_reg};
         end
      endcase
      // Read back in a fresh setup and access pair.
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got != want) report_mismatch("register read-back", got, want);
   endtask

   // Mostly key and two fixed colours so that runs and pairs form; some noise.
   function automatic logic [23:0] pick_pixel();
      int r;
      r = $urandom_range(99);
      if (r < 50) return key_reg;
      if (r < 68) return other_a;
      if (r < 85) return other_b;
      return 24'($urandom());
   endfunction

   // One random stretch: a fresh setting of some registers, then a burst of pixels.
   task automatic random_stretch(input int n_pixels);
      int r;
      logic [12:0] new_width;
      drain();
      if ($urandom_range(99) < 50) write_register(REG_KEY_COLOR, $urandom() & 32'hFFFFFF);
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(99);
         if (r < 70) new_width = 13'($urandom_range(1, 6));
         else if (r < 78) new_width = 13'd0;
         else if (r < 90) new_width = 13'($urandom_range(0, 8191));
         else new_width = 13'd4097;
         // Past the first row of an image, the row above may only be widened over
         // line store entries that have been written since reset.
         if (row_pos == 0 || size_in_use(new_width) <= line_filled)
            write_register(REG_IMAGE_WIDTH, {19'd0, new_width});
      end
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(99);
         if (r < 70) write_register(REG_IMAGE_HEIGHT, $urandom_range(1, 4));
         else if (r < 80) write_register(REG_IMAGE_HEIGHT, 0);
         else if (r < 90) write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 8191));
         else write_register(REG_IMAGE_HEIGHT, 8191);
      end
      other_a = 24'($urandom());
      other_b = 24'($urandom());
      if (other_a == key_reg) other_a = ~key_reg;
      if (other_b == key_reg) other_b = key_reg ^ 24'h000001;
      repeat (n_pixels) feed_pixel(pick_pixel());
   endtask

   // Result side: checks each accepted event against the oldest one awaited.
   always @(posedge clock) begin
      finder_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_events.size() == 0) begin
            report_mismatch("event with nothing awaited", rsp_tdata[31:0], 32'd0);
         end else begin
            want = awaited_events.pop_front();
            events_checked++;
            if (rsp_tuser != want.kind) report_mismatch("event_kind", rsp_tuser, want.kind);
            if (rsp_tdata[11:0] != want.row)
               report_mismatch("span_row", rsp_tdata[11:0], want.row);
            if (rsp_tdata[23:12] != want.first_col)
               report_mismatch("span_start", rsp_tdata[23:12], want.first_col);
            if (rsp_tdata[36:24] != want.end_col)
               report_mismatch("span_end", rsp_tdata[36:24], want.end_col);
            if (rsp_tdata[60:37] != want.color)
               report_mismatch("neighbor_color", rsp_tdata[60:37], want.color);
            if (rsp_tdata[63:61] != 3'd0)
               report_mismatch("tdata padding", rsp_tdata[63:61], 32'd0);
            if (rsp_tlast != want.last) report_mismatch("tlast", rsp_tlast, want.last);
         end
      end
      // A long hold-off is counted down here; otherwise the receiver stalls at random.
      if (result_hold_cycles > 0) begin
         result_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus: reset, directed steps, then random stretches and a long result stall.
   initial begin
      int i;
      int k;
      int phase;
      step_row_type st;
      finder_event_type ev;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      key_reg = 24'd0;
      width_reg = 13'd4096;
      height_reg = 13'd4096;
      col_pos = 0;
      row_pos = 0;
      run_open = 1'b0;
      run_first = 0;
      prev_pixel = 24'd0;
      line_filled = 0;
      result_hold_cycles = 0;
      mismatch_count = 0;
      pixels_sent = 0;
      events_checked = 0;
      send_idle_pct = 37;
      recv_idle_pct = 61;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed steps; typed rows carry their own expectation.
      for (i = 0; i < 24; i++) begin
         st = DIRECTED_STEPS[i];
         if (st.op == STEP_WRITE) begin
            drain();
            write_register(st.reg_index, {8'd0, st.value});
         end else begin
            send_pixel(st.value);
            predict_pixel_events(st.value);
            if (st.typed) begin
               if (st.typed_one) begin
                  ev.kind = st.exp_kind;
                  ev.last = 1'b1;
                  ev.row = st.exp_row;
                  ev.first_col = st.exp_first;
                  ev.end_col = st.exp_end;
                  ev.color = st.exp_color;
                  awaited_events.push_back(ev);
               end
            end else begin
               for (k = 0; k < pixel_event_count; k++) awaited_events.push_back(pixel_events[k]);
            end
         end
      end

      // Random stretches under three idling regimes.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 37 : 0;
         for (i = 0; i < 4; i++) random_stretch(7);
         if (phase == 2) begin
            // Long result stall while requests keep coming, so the block backs up.
            drain();
            write_register(REG_IMAGE_WIDTH, 5);
            result_hold_cycles = 100;
            for (i = 0; i < 30; i++) feed_pixel((i % 2 == 0) ? key_reg : pick_pixel());
         end
      end

      drain();
      $display("Run covered %0d pixel requests and %0d checked events,", pixels_sent,
               events_checked);
      $display("over register changes, three idling regimes and a long result stall.");
      if (mismatch_count == 0 && awaited_events.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
